/* src/kv_request_header_parser_defines.svh */
// assertion macros shared by the request header parser rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef KV_REQUEST_HEADER_PARSER_DEFINES_SVH
`define KV_REQUEST_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define KVHP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kvhp assertion failed");

// next-cycle implication, sampled on the rising clock edge
`define KVHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kvhp assertion failed");

`endif

/* src/kvhp_pkg.sv */
// shared constants, command word table and character class function
// for the request header parser; no dependencies
package kvhp_pkg;

  // ascii bytes the parser reacts to
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_SP   = 8'h20;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SYNTAX = 2'd1;
  localparam logic [1:0] ERR_SIZE   = 2'd2;

  // command codes
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_UPDATE = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_GET    = 3'd4;

  // size accumulator saturation point
  localparam int unsigned ACC_W = 17;
  localparam logic [ACC_W-1:0] SIZE_SAT = 17'h10000;

  // command words, in command code order
  localparam int unsigned NUM_WORDS  = 4;
  localparam int unsigned WORD_CHARS = 6;
  localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{3'd6, 3'd6, 3'd6, 3'd3};
  localparam logic [7:0] WORD_TEXT [NUM_WORDS][WORD_CHARS] = '{
    '{8'h49, 8'h4E, 8'h53, 8'h45, 8'h52, 8'h54},  // INSERT
    '{8'h55, 8'h50, 8'h44, 8'h41, 8'h54, 8'h45},  // UPDATE
    '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45},  // DELETE
    '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00}   // GET
  };

  // printable, non-separator ascii
  function automatic logic token_char_ok(input logic [7:0] b);
    logic ok;
    ok = 1'b1;
    if (b[7] || (b < CH_SP) || (b == CH_DEL)) begin
      ok = 1'b0;
    end else begin
      case (b) inside
        // ( ) < > @ , ; : \ " / [ ] ? = { } space
        8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
        8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20: begin
          ok = 1'b0;
        end
        default: begin
          ok = 1'b1;
        end
      endcase
    end
    return ok;
  endfunction

endpackage

/* src/kvhp_cmd_match.sv */
// command token matcher: compares the stored token with the command words
// depends on kvhp_pkg
module kvhp_cmd_match import kvhp_pkg::*; #(
  parameter int unsigned MAX_COMMAND_CHARS = 6,
  parameter int unsigned LEN_W             = 3
) (
  input  logic [7:0]       chars_i [MAX_COMMAND_CHARS],
  input  logic [LEN_W-1:0] len_i,
  output logic [2:0]       code_o
);

  logic [NUM_WORDS-1:0] word_hit;

  // per-word compare over the stored characters
  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      word_hit[w] = (len_i == LEN_W'(WORD_LEN[w]));
      for (int i = 0; i < WORD_CHARS; i++) begin
        if ((i < int'(WORD_LEN[w])) && (chars_i[i] != WORD_TEXT[w][i])) begin
          word_hit[w] = 1'b0;
        end
      end
    end
  end

  // lowest matching word wins
  always_comb begin
    code_o = CMD_NONE;
    for (int w = NUM_WORDS - 1; w >= 0; w--) begin
      if (word_hit[w]) begin
        code_o = 3'(w + 1);
      end
    end
  end

endmodule

/* src/kv_request_header_parser.sv */
// request header parser top level: input stage, parse logic, result stage
// depends on kvhp_pkg, kvhp_cmd_match and kv_request_header_parser_defines.svh
//
// usage:
//   input channel (in_valid_i/in_ready_o) carries one request byte per
//   transaction with a restart flag that returns the parser to command start
//   before the byte is handled. output channel (out_valid_o/out_ready_i)
//   carries exactly one result per input byte, in order.
//   cfg_we_i/cfg_wdata_i write the largest accepted key size; write it only
//   while no transaction is in flight.
//   an accepted byte passes through one input register and then one result
//   register before its result is offered on the output channel. throughput:
//   one byte per cycle while the receiver takes results; the parse logic
//   between the two registers handles one byte per cycle.
//   reset clears the parser to command start, the limit to 1024, and both
//   stages to empty. when the receiver stalls, the result register holds and
//   the input register still takes one more byte, after which in_ready_o
//   drops until the result is taken.
//
`include "kv_request_header_parser_defines.svh"

module kv_request_header_parser import kvhp_pkg::*; #(
  parameter int unsigned MAX_COMMAND_CHARS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        restart_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [1:0]  error_code_o,
  output logic [2:0]  command_code_o,
  output logic        command_done_o,
  output logic [15:0] key_size_o,
  output logic        key_size_done_o
);

  localparam int unsigned LEN_W = $clog2(MAX_COMMAND_CHARS + 2);
  localparam int unsigned PROD_W = ACC_W + 4;

  typedef enum logic [1:0] {
    PH_CMD_START,
    PH_CMD,
    PH_KEY_SIZE,
    PH_KEY
  } phase_e;

  // input stage
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_restart_q;
  logic       advance;

  // parser state
  phase_e           phase_q, phase_d, phase_eff;
  logic [LEN_W-1:0] len_q, len_d, len_eff;
  logic [ACC_W-1:0] acc_q, acc_d, acc_eff;
  logic [7:0]       chars_q [MAX_COMMAND_CHARS];
  logic [15:0]      max_key_q;
  logic             store;
  logic             tok_ok;
  logic [2:0]       match_code;
  logic [PROD_W-1:0] acc_prod;

  // result stage
  logic        out_vld_q;
  logic        status_d, status_q;
  logic [1:0]  err_d, err_q;
  logic [2:0]  code_d, code_q;
  logic        cdone_d, cdone_q;
  logic [15:0] ksize_d, ksize_q;
  logic        kdone_d, kdone_q;

  // handshake: a byte moves on when the result register is free or drains
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q    <= in_byte_i;
      in_restart_q <= restart_i;
    end
  end

  // key size limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_key_q <= 16'd1024;
    end else if (cfg_we_i) begin
      max_key_q <= cfg_wdata_i;
    end
  end

  // command word match on the stored token
  kvhp_cmd_match #(
    .MAX_COMMAND_CHARS(MAX_COMMAND_CHARS),
    .LEN_W            (LEN_W)
  ) u_cmd_match (
    .chars_i(chars_q),
    .len_i  (len_q),
    .code_o (match_code)
  );

  // restart applies before the byte is handled
  assign phase_eff = in_restart_q ? PH_CMD_START : phase_q;
  assign len_eff   = in_restart_q ? '0 : len_q;
  assign acc_eff   = in_restart_q ? '0 : acc_q;
  assign tok_ok    = token_char_ok(in_byte_q);

  // acc * 10 + digit
  assign acc_prod = (PROD_W'(acc_eff) << 3) + (PROD_W'(acc_eff) << 1)
                  + PROD_W'(in_byte_q[3:0]);

  // per-byte parse
  always_comb begin
    phase_d  = phase_eff;
    len_d    = len_eff;
    acc_d    = acc_eff;
    store    = 1'b0;
    status_d = 1'b0;
    err_d    = ERR_NONE;
    code_d   = CMD_NONE;
    cdone_d  = 1'b0;
    ksize_d  = '0;
    kdone_d  = 1'b0;
    case (phase_eff)
      PH_CMD_START: begin
        if (!tok_ok) begin
          status_d = 1'b1;
          err_d    = ERR_SYNTAX;
        end else begin
          store   = 1'b1;
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        if (in_byte_q == CH_LF) begin
          len_d = '0;
          if (match_code == CMD_NONE) begin
            status_d = 1'b1;
            err_d    = ERR_SYNTAX;
          end else begin
            code_d  = match_code;
            cdone_d = 1'b1;
            phase_d = PH_KEY_SIZE;
          end
        end else if (in_byte_q == CH_CR) begin
          // carriage return ignored
        end else if (!tok_ok) begin
          status_d = 1'b1;
          err_d    = ERR_SYNTAX;
        end else begin
          store = 1'b1;
        end
      end
      PH_KEY_SIZE: begin
        if (in_byte_q == CH_LF) begin
          acc_d = '0;
          if (acc_eff > ACC_W'(max_key_q)) begin
            status_d = 1'b1;
            err_d    = ERR_SIZE;
          end else begin
            ksize_d = acc_eff[15:0];
            kdone_d = 1'b1;
            phase_d = PH_KEY;
          end
        end else if (in_byte_q == CH_CR) begin
          // carriage return ignored
        end else if ((in_byte_q < CH_ZERO) || (in_byte_q > CH_NINE)) begin
          status_d = 1'b1;
          err_d    = ERR_SYNTAX;
        end else if (acc_prod > PROD_W'(SIZE_SAT)) begin
          acc_d = SIZE_SAT;
        end else begin
          acc_d = acc_prod[ACC_W-1:0];
        end
      end
      default: begin
        // key phase absorbs bytes
      end
    endcase
    // token length saturates one past the buffer size
    if (store && (len_eff <= LEN_W'(MAX_COMMAND_CHARS))) begin
      len_d = len_eff + 1'b1;
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CMD_START;
      len_q   <= '0;
      acc_q   <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      acc_q   <= acc_d;
    end
  end

  // token buffer, one write port
  for (genvar e = 0; e < MAX_COMMAND_CHARS; e++) begin : g_chars
    always_ff @(posedge clk_i) begin
      if (advance && store && (len_eff == LEN_W'(e))) begin
        chars_q[e] <= in_byte_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      err_q    <= err_d;
      code_q   <= code_d;
      cdone_q  <= cdone_d;
      ksize_q  <= ksize_d;
      kdone_q  <= kdone_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = status_q;
  assign error_code_o    = err_q;
  assign command_code_o  = code_q;
  assign command_done_o  = cdone_q;
  assign key_size_o      = ksize_q;
  assign key_size_done_o = kdone_q;

  // checks
  `KVHP_ASSERT_IMPL(a_stall_blocks_advance, out_vld_q && !out_ready_i, !advance)
  `KVHP_ASSERT_IMPL(a_reject_has_error,
    out_vld_q && status_q, (err_q != ERR_NONE) && !cdone_q && !kdone_q)
  `KVHP_ASSERT_IMPL(a_done_has_code,
    out_vld_q && cdone_q, !status_q && (code_q != CMD_NONE))
  `KVHP_ASSERT_IMPL(a_len_clear_past_cmd,
    (phase_q == PH_KEY_SIZE) || (phase_q == PH_KEY), len_q == '0)
  `KVHP_ASSERT_IMPL(a_acc_clear_outside_size,
    phase_q != PH_KEY_SIZE, acc_q == '0)
  `KVHP_ASSERT_NEXT(a_acc_bounded, 1'b1, acc_q <= SIZE_SAT)

endmodule
